/* sv/mre_pkg.sv */
// Package for the MIPS-like execute unit: payload structs, opcodes, controller types.
// Used by the controller, datapath and top level; no dependencies.
package mre_pkg;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_SUB = 6'd2, OP_AND = 6'd3, OP_OR = 6'd4,
    OP_XOR = 6'd5, OP_NOR = 6'd6, OP_NAND = 6'd7, OP_SLT = 6'd8, OP_SLL = 6'd9,
    OP_SRL = 6'd10, OP_SRA = 6'd11, OP_JR = 6'd12, OP_ADDI = 6'd13, OP_ADDIU = 6'd14,
    OP_LW = 6'd15, OP_LH = 6'd16, OP_LHU = 6'd17, OP_LB = 6'd18, OP_LBU = 6'd19,
    OP_SW = 6'd20, OP_SH = 6'd21, OP_SB = 6'd22, OP_LUI = 6'd23, OP_ANDI = 6'd24,
    OP_ORI = 6'd25, OP_NORI = 6'd26, OP_SLTI = 6'd27, OP_BEQ = 6'd28, OP_BNE = 6'd29,
    OP_BGTZ = 6'd30, OP_J = 6'd31, OP_JAL = 6'd32, OP_HALT = 6'd33
  } op_e;

  localparam logic [4:0]  LINK_REG   = 5'd31;
  localparam logic [31:0] HALF_EXT   = 32'hFFFF0000;
  localparam logic [31:0] BYTE_EXT   = 32'hFFFFFF00;
  localparam logic [31:0] REGION_MSK = 32'hF0000000;

  typedef struct packed {
    logic [5:0]  action;
    logic [4:0]  src_index;
    logic [4:0]  second_index;
    logic [4:0]  dest_field;
    logic [4:0]  shift_amount;
    logic [31:0] immediate;
    logic [25:0] jump_target;
    logic [31:0] current_pc;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [9:0]  mem_address;
    logic [2:0]  access_bytes;
    logic        address_fault;
    logic        zero_write;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_CLEAR, ST_EXEC, ST_FINISH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;   // capture input transaction
    logic clear_step;  // write zero to one memory word
    logic exec;        // decode, issue memory access, register item
    logic finish;      // merge load data, write register file, load result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
  } status_t;

endpackage

/* sv/mre_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module mre_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* sv/mre_ctrl.sv */
// Controller: clearing pass after reset, then capture, execute and finish states per instruction.
// Depends on mre_pkg.
module mre_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  mre_pkg::status_t status_i,
  output mre_pkg::cmd_t    cmd_o
);
  mre_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mre_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mre_pkg::ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_done) state_d = mre_pkg::ST_IDLE;
      end
      mre_pkg::ST_IDLE: begin
        // the output register may be refilled when empty or draining now
        in_ready_o = !out_valid_i || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          cmd_o.load_item = 1'b1;
          state_d = mre_pkg::ST_EXEC;
        end
      end
      mre_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = mre_pkg::ST_FINISH;
      end
      mre_pkg::ST_FINISH: begin
        if (!out_valid_i || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d = mre_pkg::ST_IDLE;
        end
      end
      default: state_d = mre_pkg::ST_CLEAR;
    endcase
  end
endmodule

/* sv/mre_datapath.sv */
// Datapath: register file, byte-lane data memory, ALU, branch unit, result register.
// Depends on mre_pkg and mre_ram.
module mre_datapath #(
  parameter int MemBytes = 1024,
  parameter int StackReg = 29
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mre_pkg::cmd_t       cmd_i,
  output mre_pkg::status_t    status_o,
  input  mre_pkg::in_item_t   item_i,
  input  logic                cfg_valid_i,
  input  logic [31:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mre_pkg::out_item_t  out_o
);
  localparam int Words = MemBytes / 4;
  localparam int WaW   = (Words > 1) ? $clog2(Words) : 1;
  localparam logic [4:0] StackIdx = 5'(StackReg);

  // register file: flops, reset to zero
  logic [31:0] rf_q [32];
  mre_pkg::in_item_t it_q;
  mre_pkg::out_item_t res_q, res_d;
  logic out_valid_q;
  logic [WaW:0] clr_q;

  // decoded/executed state between EXEC and FINISH
  logic [31:0] val_q, next_q, addr_q;
  logic [2:0]  size_q;
  logic        fault_q, is_load_q, has_dest_q, store_q;
  logic [4:0]  dest_q;
  logic [5:0]  op_q;

  // combinational execute
  logic [31:0] rs, rt, seq, addr, val, nxt, br_tgt;
  logic [2:0]  size;
  logic        has_dest, is_store, fault;
  logic [4:0]  dest;
  logic [32:0] end_addr;

  always_comb begin
    rs  = rf_q[it_q.src_index];
    rt  = rf_q[it_q.second_index];
    seq = it_q.current_pc + 32'd4;
    br_tgt = seq + {it_q.immediate[29:0], 2'b00};
    addr = rs + it_q.immediate;
    nxt = seq;
    val = '0;
    size = 3'd0;
    has_dest = 1'b0;
    dest = '0;
    case (it_q.action)
      mre_pkg::OP_ADD, mre_pkg::OP_ADDU: val = rs + rt;
      mre_pkg::OP_SUB:  val = rs - rt;
      mre_pkg::OP_AND:  val = rs & rt;
      mre_pkg::OP_OR:   val = rs | rt;
      mre_pkg::OP_XOR:  val = rs ^ rt;
      mre_pkg::OP_NOR:  val = ~(rs | rt);
      mre_pkg::OP_NAND: val = ~(rs & rt);
      mre_pkg::OP_SLT:  val = {31'd0, $signed(rs) < $signed(rt)};
      mre_pkg::OP_SLL:  val = rt << it_q.shift_amount;
      mre_pkg::OP_SRL:  val = rt >> it_q.shift_amount;
      mre_pkg::OP_SRA:  val = $unsigned($signed(rt) >>> it_q.shift_amount);
      mre_pkg::OP_JR:   nxt = rs;
      mre_pkg::OP_ADDI, mre_pkg::OP_ADDIU: val = rs + it_q.immediate;
      mre_pkg::OP_LW, mre_pkg::OP_SW: size = 3'd4;
      mre_pkg::OP_LH, mre_pkg::OP_LHU, mre_pkg::OP_SH: size = 3'd2;
      mre_pkg::OP_LB, mre_pkg::OP_LBU, mre_pkg::OP_SB: size = 3'd1;
      mre_pkg::OP_LUI:  val = {it_q.immediate[15:0], 16'd0};
      mre_pkg::OP_ANDI: val = rs & it_q.immediate;
      mre_pkg::OP_ORI:  val = rs | it_q.immediate;
      mre_pkg::OP_NORI: val = ~(rs | it_q.immediate);
      mre_pkg::OP_SLTI: val = {31'd0, $signed(rs) < $signed(it_q.immediate)};
      mre_pkg::OP_BEQ:  if (rs == rt) nxt = br_tgt;
      mre_pkg::OP_BNE:  if (rs != rt) nxt = br_tgt;
      mre_pkg::OP_BGTZ: if (!rs[31] && rs != '0) nxt = br_tgt;
      mre_pkg::OP_J:    nxt = (seq & mre_pkg::REGION_MSK) | {4'd0, it_q.jump_target, 2'b00};
      mre_pkg::OP_JAL: begin
        nxt = (seq & mre_pkg::REGION_MSK) | {4'd0, it_q.jump_target, 2'b00};
        val = seq;
      end
      mre_pkg::OP_HALT: nxt = it_q.current_pc;
      default: ;
    endcase
    if (it_q.action <= mre_pkg::OP_SRA) begin
      has_dest = 1'b1;
      dest = it_q.dest_field;
    end else if ((it_q.action >= mre_pkg::OP_ADDI && it_q.action <= mre_pkg::OP_LBU) ||
                 (it_q.action >= mre_pkg::OP_LUI && it_q.action <= mre_pkg::OP_SLTI)) begin
      has_dest = 1'b1;
      dest = it_q.second_index;
    end else if (it_q.action == mre_pkg::OP_JAL) begin
      has_dest = 1'b1;
      dest = mre_pkg::LINK_REG;
    end
    is_store = it_q.action >= mre_pkg::OP_SW && it_q.action <= mre_pkg::OP_SB;
    end_addr = {1'b0, addr} + 33'(size);
    fault = (size != 3'd0) && (end_addr > 33'(MemBytes));
  end

  // Memory: four byte lanes, lane k holds byte addresses 4w+k. An access of up to
  // four bytes touches words w and w+1; each lane picks its word by its offset.
  logic [1:0]     off;
  logic [WaW-1:0] wbase;
  logic [3:0]     lane_we;
  logic [WaW-1:0] lane_addr [4];
  logic [7:0]     lane_wd [4];
  logic [7:0]     lane_rd [4];
  logic [1:0]     off_q;

  always_comb begin
    off   = addr[1:0];
    wbase = addr[WaW+1:2];
    for (int k = 0; k < 4; k++) begin
      logic [1:0] pos;    // byte position in the access, big-endian
      pos = 2'(k) - off;
      lane_addr[k] = (2'(k) < off) ? wbase + WaW'(1) : wbase;
      lane_we[k]   = cmd_i.exec && is_store && !fault && (3'(pos) < size);
      lane_wd[k]   = rt[8*(3'(size) - 3'd1 - 3'(pos)) +: 8];
      if (cmd_i.clear_step) begin
        lane_addr[k] = clr_q[WaW-1:0];
        lane_we[k]   = 1'b1;
        lane_wd[k]   = '0;
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    mre_ram #(.Width(8), .Depth(Words)) u_ram (
      .clk_i   (clk_i),
      .we_i    (lane_we[g]),
      .addr_i  (lane_addr[g]),
      .wdata_i (lane_wd[g]),
      .rdata_o (lane_rd[g])
    );
  end

  assign status_o.clear_done = (clr_q == (WaW+1)'(Words - 1));

  // assemble load data from lanes
  logic [31:0] ld;
  logic [31:0] load_val;
  always_comb begin
    ld = '0;
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < size_q) begin
        ld = {ld[23:0], lane_rd[2'(off_q + 2'(j))]};
      end
    end
    load_val = ld;
    if (op_q == mre_pkg::OP_LH && ld[15]) load_val = ld | mre_pkg::HALF_EXT;
    if (op_q == mre_pkg::OP_LB && ld[7])  load_val = ld | mre_pkg::BYTE_EXT;
  end

  logic [31:0] wval;
  logic        reg_w, zero_w;
  always_comb begin
    wval   = is_load_q ? load_val : val_q;
    zero_w = has_dest_q && dest_q == '0;
    reg_w  = has_dest_q && dest_q != '0 && !fault_q;
    res_d.next_pc       = next_q;
    res_d.reg_written   = reg_w;
    res_d.reg_index     = reg_w ? dest_q : '0;
    res_d.reg_value     = reg_w ? wval : '0;
    res_d.mem_written   = store_q;
    res_d.mem_address   = (size_q != 3'd0) ? addr_q[9:0] : '0;
    res_d.access_bytes  = size_q;
    res_d.address_fault = fault_q;
    res_d.zero_write    = zero_w;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) it_q <= item_i;
    if (cmd_i.exec) begin
      val_q      <= val;
      next_q     <= nxt;
      addr_q     <= addr;
      size_q     <= size;
      fault_q    <= fault;
      is_load_q  <= (size != 3'd0) && !is_store;
      store_q    <= is_store && !fault;
      has_dest_q <= has_dest;
      dest_q     <= dest;
      op_q       <= it_q.action;
      off_q      <= off;
    end
    if (cmd_i.finish) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      for (int r = 0; r < 32; r++) rf_q[r] <= '0;
    end else begin
      if (cmd_i.clear_step && !status_o.clear_done) clr_q <= clr_q + 1'b1;
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.finish && reg_w) rf_q[dest_q] <= wval;
      if (cfg_valid_i && StackIdx != 5'd0) rf_q[StackIdx] <= cfg_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;
endmodule

/* sv/mips_register_file_execute.sv */
// Top level of the MIPS-like execute unit: controller plus datapath.
// Depends on mre_pkg, mre_ctrl, mre_datapath, mre_ram.
//
// Usage:
//  in_valid_i/in_ready_o carry one decoded instruction per transaction;
//  out_valid_o/out_ready_i return exactly one result per instruction, in order.
//  cfg_valid_i/cfg_ready_o write the initial stack pointer, which loads
//  register STACK_REG at once; write it only while the unit is idle.
//  Sequence: the input transaction is captured, executed with the data memory
//  read or write, and then written back to the register file and output register.
//  Issue: a new instruction is taken only after the previous one has passed the
//  capture, execute and write-back steps; write-back waits on the synchronous memory read.
//  Reset: register file cleared by reset; then a clearing pass over data memory
//  writes all MEM_BYTES/4 rows, one 4-byte row per cycle, during which no
//  instruction is accepted (configuration writes are taken).
//  Stall: a held result stays in the output register; a new instruction is
//  taken only when that register is free or drains in the same cycle.
module mips_register_file_execute #(
  parameter int MEM_BYTES = 1024,
  parameter int STACK_REG = 29
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mre_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mre_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);
  mre_pkg::cmd_t    cmd;
  mre_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  mre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mre_datapath #(.MemBytes(MEM_BYTES), .StackReg(STACK_REG)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .item_i      (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_data_o)
  );

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_item, cmd.clear_step, cmd.exec, cmd.finish}))
    else $error("controller issued overlapping commands");
  a_exec_follows_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_item |=> cmd.exec)
    else $error("execute did not follow capture");
  a_no_reg0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.reg_written && out_data_o.reg_index == 5'd0))
    else $error("register zero reported written");
  a_fault_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.address_fault |->
      !out_data_o.mem_written && !out_data_o.reg_written)
    else $error("faulting access took effect");
`endif
endmodule
